// File: rtl/rcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcbp_pkg;

	// Fixed shape of the block
	localparam int NUM_POOLS      = 3;
	localparam int POOL_W         = 2;
	localparam int FUNC_W         = 2;
	localparam int STATUS_W       = 3;

	// Defaults for the top level parameters
	localparam int POOL_DEPTH_DEF = 32;
	localparam int REF_LIMIT_DEF  = 15;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [POOL_W-1:0]   pool_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Request operations
	localparam func_t FN_ALLOC   = 2'd0;
	localparam func_t FN_RELEASE = 2'd1;
	localparam func_t FN_FORCE   = 2'd2;
	localparam func_t FN_ADDREF  = 2'd3;

	// Result status codes
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_EMPTY     = 3'd1;
	localparam status_t ST_OVERFLOW  = 3'd2;
	localparam status_t ST_UNDERFLOW = 3'd3;
	localparam status_t ST_BAD_POOL  = 3'd4;

	// Which state a request updates
	typedef struct packed {
		logic pool_we;   // free head, used and peak of the addressed pool
		logic mem_we;    // link and reference count of the addressed slot
	} upd_ctl_t;

endpackage

`default_nettype wire

// File: rtl/rcbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port (old data on a collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/rcbp_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_slot_store #(
	parameter int POOL_DEPTH = 32,
	parameter int REF_LIMIT  = 15
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            rd_en,
	input  wire logic [$clog2(rcbp_pkg::NUM_POOLS*POOL_DEPTH)-1:0] rd_slot,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0]                 rd_idx,
	input  wire logic                                            wr_en,
	input  wire logic [$clog2(rcbp_pkg::NUM_POOLS*POOL_DEPTH)-1:0] wr_slot,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0]                 wr_link,
	input  wire logic [$clog2(REF_LIMIT+1)-1:0]                  wr_ref,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]                 rd_link,
	output logic      [$clog2(REF_LIMIT+1)-1:0]                  rd_ref
);

	import rcbp_pkg::*;

	localparam int SLOTS = NUM_POOLS * POOL_DEPTH;
	localparam int LW    = $clog2(POOL_DEPTH + 1);
	localparam int RW    = $clog2(REF_LIMIT + 1);
	localparam int DW    = LW + RW;

	logic [SLOTS-1:0] written_q;
	logic [DW-1:0]    ram_rdata;
	logic             rd_written_q;
	logic             rd_hit_q;
	logic [LW-1:0]    rd_idx_q;
	logic [DW-1:0]    byp_data_q;
	logic [LW-1:0]    init_link;

	rcbp_ram #(
		.WIDTH(DW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_slot),
		.wdata({wr_link, wr_ref}),
		.re   (rd_en),
		.raddr(rd_slot),
		.rdata(ram_rdata)
	);

	// Per-slot written flags: an unwritten slot reads as its reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_slot] <= 1'b1;
		end
	end

	// Read-side side information, captured with the RAM read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_written_q <= written_q[rd_slot];
			rd_hit_q     <= wr_en && (wr_slot == rd_slot);
			rd_idx_q     <= rd_idx;
			byp_data_q   <= {wr_link, wr_ref};
		end
	end

	// Reset link of entry i is i+1
	assign init_link = rd_idx_q + LW'(1);

	// Same-cycle write wins, then stored data, then reset contents
	always_comb begin
		if (rd_hit_q) begin
			{rd_link, rd_ref} = byp_data_q;
		end else if (rd_written_q) begin
			{rd_link, rd_ref} = ram_rdata;
		end else begin
			rd_link = init_link;
			rd_ref  = '0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rcbp_op_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_op_unit #(
	parameter int POOL_DEPTH = 32,
	parameter int REF_LIMIT  = 15
) (
	input  wire rcbp_pkg::func_t                  func,
	input  wire rcbp_pkg::pool_t                  pool,
	input  wire logic [$clog2(POOL_DEPTH)-1:0]    handle,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0]  head,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0]  used,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0]  peak,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0]  rd_link,
	input  wire logic [$clog2(REF_LIMIT+1)-1:0]   rd_ref,
	output rcbp_pkg::status_t                     status,
	output logic      [$clog2(POOL_DEPTH)-1:0]    buffer_index,
	output logic      [$clog2(REF_LIMIT+1)-1:0]   refs,
	output logic                                  freed,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]  in_use,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]  peak_use,
	output rcbp_pkg::upd_ctl_t                    ctl,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]  head_new,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]  used_new,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]  peak_new,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]  link_new,
	output logic      [$clog2(REF_LIMIT+1)-1:0]   ref_new
);

	import rcbp_pkg::*;

	localparam int HW = $clog2(POOL_DEPTH);
	localparam int LW = $clog2(POOL_DEPTH + 1);
	localparam int RW = $clog2(REF_LIMIT + 1);
	localparam logic [LW-1:0] DEPTH_L = LW'(POOL_DEPTH);
	localparam logic [RW-1:0] REF_MAX = RW'(REF_LIMIT);

	logic [LW-1:0] handle_ext;
	logic [LW-1:0] used_inc;
	logic [LW-1:0] used_dec;

	assign handle_ext = LW'(handle);

	// Saturating used count steps
	assign used_inc = (used < DEPTH_L) ? used + LW'(1) : used;
	assign used_dec = (used != '0) ? used - LW'(1) : used;

	// Decode one request against the pool state and the slot contents
	always_comb begin
		status       = ST_OK;
		buffer_index = handle;
		refs         = '0;
		freed        = 1'b0;
		in_use       = used;
		peak_use     = peak;
		ctl          = '0;
		head_new     = head;
		used_new     = used;
		peak_new     = peak;
		link_new     = rd_link;
		ref_new      = rd_ref;

		if (pool >= POOL_W'(NUM_POOLS)) begin
			status   = ST_BAD_POOL;
			in_use   = '0;
			peak_use = '0;
		end else if (func == FN_ALLOC) begin
			if (head >= DEPTH_L) begin
				status       = ST_EMPTY;
				buffer_index = '0;
			end else begin
				// Pop the head, count starts at one
				ctl.pool_we  = 1'b1;
				ctl.mem_we   = 1'b1;
				head_new     = rd_link;
				ref_new      = RW'(1);
				used_new     = used_inc;
				peak_new     = (used_inc >= peak) ? used_inc : peak;
				buffer_index = head[HW-1:0];
				refs         = RW'(1);
				in_use       = used_inc;
				peak_use     = peak_new;
			end
		end else if (handle_ext >= DEPTH_L) begin
			status = ST_BAD_POOL;
		end else begin
			case (func)
				FN_RELEASE: begin
					if (rd_ref == '0) begin
						status = ST_UNDERFLOW;
					end else begin
						ctl.mem_we = 1'b1;
						ref_new    = rd_ref - RW'(1);
						if (rd_ref == RW'(1)) begin
							// Last reference gone: push back on the free list
							ctl.pool_we = 1'b1;
							link_new    = head;
							head_new    = handle_ext;
							used_new    = used_dec;
							freed       = 1'b1;
							in_use      = used_dec;
						end else begin
							refs = ref_new;
						end
					end
				end
				FN_FORCE: begin
					ctl.pool_we = 1'b1;
					ctl.mem_we  = 1'b1;
					link_new    = head;
					head_new    = handle_ext;
					used_new    = used_dec;
					refs        = rd_ref;
					freed       = 1'b1;
					in_use      = used_dec;
				end
				FN_ADDREF: begin
					if (rd_ref >= REF_MAX) begin
						status = ST_OVERFLOW;
						refs   = rd_ref;
					end else begin
						ctl.mem_we = 1'b1;
						ref_new    = rd_ref + RW'(1);
						refs       = ref_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/refcounted_buffer_pool_manager.sv
`timescale 1ns / 1ps
`default_nettype none

// Buffer allocator over three pools of POOL_DEPTH buffers, each pool a LIFO free list
// with a reference count per buffer. One request (allocate, release, force free, add
// reference) may be accepted on every clock while the pipeline is not stalled; its result
// passes through the request stage into the result register. The slot RAM (link and count
// of every buffer) has one read and one write port; it is read as the request is accepted
// and written as the request leaves the request stage, with a write to the slot being read
// passed straight through, and the free-list heads are forwarded so that back-to-back
// requests on the same pool see each other's updates. No clearing pass is needed after
// reset: unwritten slots read as their reset contents. A stalled result holds the pipeline.
module refcounted_buffer_pool_manager #(
	parameter int POOL_DEPTH = rcbp_pkg::POOL_DEPTH_DEF,
	parameter int REF_LIMIT  = rcbp_pkg::REF_LIMIT_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire rcbp_pkg::func_t                      func,
	input  wire rcbp_pkg::pool_t                      pool,
	input  wire logic [$clog2(POOL_DEPTH)-1:0]        handle,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	output rcbp_pkg::status_t                         status,
	output logic      [$clog2(POOL_DEPTH)-1:0]        buffer_index,
	output logic      [$clog2(REF_LIMIT+1)-1:0]       refs,
	output logic                                      freed,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]      in_use,
	output logic      [$clog2(POOL_DEPTH+1)-1:0]      peak_use
);

	import rcbp_pkg::*;

	localparam int HW    = $clog2(POOL_DEPTH);
	localparam int LW    = $clog2(POOL_DEPTH + 1);
	localparam int RW    = $clog2(REF_LIMIT + 1);
	localparam int SLOTS = NUM_POOLS * POOL_DEPTH;
	localparam int SW    = $clog2(SLOTS);

	// Pool state
	logic [LW-1:0] free_head_q [NUM_POOLS];
	logic [LW-1:0] used_q      [NUM_POOLS];
	logic [LW-1:0] peak_q      [NUM_POOLS];
	logic [LW-1:0] free_head_d [NUM_POOLS];
	logic [LW-1:0] used_d      [NUM_POOLS];
	logic [LW-1:0] peak_d      [NUM_POOLS];

	// Request stage
	logic          valid_s1;
	func_t         func_s1;
	pool_t         pool_s1;
	logic [HW-1:0] handle_s1;
	logic [SW-1:0] slot_s1;
	logic [LW-1:0] head_s1;
	logic [LW-1:0] used_s1;
	logic [LW-1:0] peak_s1;

	// Result register
	logic          rsp_valid_q;
	status_t       status_q;
	logic [HW-1:0] buffer_index_q;
	logic [RW-1:0] refs_q;
	logic          freed_q;
	logic [LW-1:0] in_use_q;
	logic [LW-1:0] peak_use_q;

	logic          accept;
	logic          s1_fire;
	logic [LW-1:0] sel_head;
	logic [LW-1:0] sel_used;
	logic [LW-1:0] sel_peak;
	logic [LW-1:0] rd_idx;
	logic          rd_ok;
	logic [SW-1:0] rd_slot;
	logic [LW-1:0] rd_link;
	logic [RW-1:0] rd_ref;

	status_t       op_status;
	logic [HW-1:0] op_buffer_index;
	logic [RW-1:0] op_refs;
	logic          op_freed;
	logic [LW-1:0] op_in_use;
	logic [LW-1:0] op_peak_use;
	upd_ctl_t      op_ctl;
	logic [LW-1:0] head_new;
	logic [LW-1:0] used_new;
	logic [LW-1:0] peak_new;
	logic [LW-1:0] link_new;
	logic [RW-1:0] ref_new;

	// Flow control: the request stage moves when the result register is free
	assign s1_fire   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !s1_fire;
	assign accept    = req_valid && !req_stall;

	// Pool state as it stands after this cycle's update
	always_comb begin
		for (int p = 0; p < NUM_POOLS; p++) begin
			if (s1_fire && op_ctl.pool_we && (pool_s1 == POOL_W'(p))) begin
				free_head_d[p] = head_new;
				used_d[p]      = used_new;
				peak_d[p]      = peak_new;
			end else begin
				free_head_d[p] = free_head_q[p];
				used_d[p]      = used_q[p];
				peak_d[p]      = peak_q[p];
			end
		end
	end

	// Select the incoming request's pool; an invalid pool looks empty
	always_comb begin
		sel_head = LW'(POOL_DEPTH);
		sel_used = '0;
		sel_peak = '0;
		for (int p = 0; p < NUM_POOLS; p++) begin
			if (pool == POOL_W'(p)) begin
				sel_head = free_head_d[p];
				sel_used = used_d[p];
				sel_peak = peak_d[p];
			end
		end
	end

	// Slot to read: the free head for an allocation, else the handle
	assign rd_idx  = (func == FN_ALLOC) ? sel_head : LW'(handle);
	assign rd_ok   = (pool < POOL_W'(NUM_POOLS)) && (rd_idx < LW'(POOL_DEPTH));
	assign rd_slot = rd_ok ? (SW'(pool) * SW'(POOL_DEPTH) + SW'(rd_idx)) : '0;

	rcbp_slot_store #(
		.POOL_DEPTH(POOL_DEPTH),
		.REF_LIMIT (REF_LIMIT)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_slot(rd_slot),
		.rd_idx (rd_idx),
		.wr_en  (s1_fire && op_ctl.mem_we),
		.wr_slot(slot_s1),
		.wr_link(link_new),
		.wr_ref (ref_new),
		.rd_link(rd_link),
		.rd_ref (rd_ref)
	);

	rcbp_op_unit #(
		.POOL_DEPTH(POOL_DEPTH),
		.REF_LIMIT (REF_LIMIT)
	) u_op (
		.func        (func_s1),
		.pool        (pool_s1),
		.handle      (handle_s1),
		.head        (head_s1),
		.used        (used_s1),
		.peak        (peak_s1),
		.rd_link     (rd_link),
		.rd_ref      (rd_ref),
		.status      (op_status),
		.buffer_index(op_buffer_index),
		.refs        (op_refs),
		.freed       (op_freed),
		.in_use      (op_in_use),
		.peak_use    (op_peak_use),
		.ctl         (op_ctl),
		.head_new    (head_new),
		.used_new    (used_new),
		.peak_new    (peak_new),
		.link_new    (link_new),
		.ref_new     (ref_new)
	);

	// Pool state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				free_head_q[p] <= '0;
				used_q[p]      <= '0;
				peak_q[p]      <= '0;
			end
		end else begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				free_head_q[p] <= free_head_d[p];
				used_q[p]      <= used_d[p];
				peak_q[p]      <= peak_d[p];
			end
		end
	end

	// Request stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Request stage payload, with the pool state it will work on
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			pool_s1   <= pool;
			handle_s1 <= handle;
			slot_s1   <= rd_slot;
			head_s1   <= sel_head;
			used_s1   <= sel_used;
			peak_s1   <= sel_peak;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q       <= op_status;
			buffer_index_q <= op_buffer_index;
			refs_q         <= op_refs;
			freed_q        <= op_freed;
			in_use_q       <= op_in_use;
			peak_use_q     <= op_peak_use;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign buffer_index = buffer_index_q;
	assign refs         = refs_q;
	assign freed        = freed_q;
	assign in_use       = in_use_q;
	assign peak_use     = peak_use_q;

endmodule

`default_nettype wire

// File: rtl/rcbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_checker #(
	parameter int POOL_DEPTH = rcbp_pkg::POOL_DEPTH_DEF,
	parameter int REF_LIMIT  = rcbp_pkg::REF_LIMIT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	input  wire logic                            req_stall,
	input  wire rcbp_pkg::func_t                 func,
	input  wire rcbp_pkg::pool_t                 pool,
	input  wire logic [$clog2(POOL_DEPTH)-1:0]   handle,
	input  wire logic                            rsp_valid,
	input  wire logic                            rsp_stall,
	input  wire rcbp_pkg::status_t               status,
	input  wire logic [$clog2(POOL_DEPTH)-1:0]   buffer_index,
	input  wire logic [$clog2(REF_LIMIT+1)-1:0]  refs,
	input  wire logic                            freed,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0] in_use,
	input  wire logic [$clog2(POOL_DEPTH+1)-1:0] peak_use
);

	import rcbp_pkg::*;

	localparam int RW = $clog2(REF_LIMIT + 1);

	// A stalled result transfer keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(buffer_index)
			&& $stable(refs) && $stable(freed) && $stable(in_use) && $stable(peak_use))
		else $error("result changed while stalled");

	// The high-water mark never trails the used count
	a_peak_covers_use: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> in_use <= peak_use)
		else $error("in_use above peak_use");

	// Only a successful request returns a buffer
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && freed |-> status == ST_OK)
		else $error("freed flag on a failed request");

	// A rejected pool or handle reports no count
	a_bad_pool: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_BAD_POOL |-> refs == '0 && !freed)
		else $error("bad pool result carries a count");

	// Overflow only ever happens at the limit
	a_overflow_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OVERFLOW |-> refs == RW'(REF_LIMIT))
		else $error("overflow below the reference limit");

endmodule

bind refcounted_buffer_pool_manager rcbp_checker #(
	.POOL_DEPTH(POOL_DEPTH),
	.REF_LIMIT (REF_LIMIT)
) u_rcbp_checker (.*);

`default_nettype wire
